// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

`endif

// ===== sv/imf_pkg.sv =====
// Shared constants, register indexes and controller/datapath signal groups
// for the image median filter. No dependencies.
package imf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_RADIUS = 3;
    localparam int PIX_BITS   = 16;
    localparam int COL_BITS   = 10;
    localparam int ROW_BITS   = 12;
    localparam int WID_BITS   = 11;
    localparam int HGT_BITS   = 13;
    localparam int RAD_BITS   = 2;
    localparam int CFG_BITS   = 13;
    localparam int IDX_BITS   = 2;
    localparam int RING_ROWS  = 3 * MAX_RADIUS + 1;
    localparam int RING_BITS  = 4;
    localparam int ADDR_BITS  = RING_BITS + COL_BITS;
    localparam int MEM_DEPTH  = RING_ROWS * MAX_WIDTH;
    localparam int WIN_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int WIN_MAX    = WIN_SIDE * WIN_SIDE;
    localparam int CNT_BITS   = 6;
    localparam int POS_BITS   = 24;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_RADIUS = 2'd2;

    typedef struct packed {
        logic latch;
        logic store;
        logic start_win;
        logic rd_issue;
        logic sel_shift;
        logic emit;
    } imf_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic win_last;
        logic sel_done;
        logic out_free;
    } imf_status_t;

endpackage

// ===== sv/image_median_filter.sv =====
// Top level of the streaming square-window median filter.
// Depends on imf_pkg, imf_ctrl and imf_datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | into      | in_valid/in_stall  | action, pixel
//  out     | out of    | out_valid/out_stall| median, out_col, out_row, frame_last
//  cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// An item that only stores a pixel passes the idle, store and test states; one that
// releases an output goes on through read (one line-store read per pixel of the
// clipped window, up to 49), drain, select (one shift per selection step) and emit,
// which waits out any output stall. in_stall is low only in the idle state. Reset is
// asynchronous and needs no clearing pass; a register write restarts the frame.
module image_median_filter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [imf_pkg::PIX_BITS-1:0]    pixel,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [imf_pkg::PIX_BITS-1:0]    median,
    output logic [imf_pkg::COL_BITS-1:0]    out_col,
    output logic [imf_pkg::ROW_BITS-1:0]    out_row,
    output logic                            frame_last,
    input  logic                            cfg_we,
    input  logic [imf_pkg::IDX_BITS-1:0]    cfg_index,
    input  logic [imf_pkg::CFG_BITS-1:0]    cfg_data
);
    import imf_pkg::*;

    imf_cmd_t    cmd;
    imf_status_t status;

    imf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    imf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .action     (action),
        .pixel      (pixel),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .median     (median),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_last (frame_last),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

// ===== sv/imf_ctrl.sv =====
// Controller state machine for the image median filter.
// Depends on imf_pkg.
module imf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  imf_pkg::imf_status_t status,
    output imf_pkg::imf_cmd_t    cmd
);
    import imf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_STORE  = 7'b0000010,
        S_TEST   = 7'b0000100,
        S_READ   = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_SELECT = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (status.emit_ok)
                begin
                    cmd.start_win = 1'b1;
                    state_next    = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                if (status.win_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SELECT;
            end
            S_SELECT:
            begin
                if (status.sel_done)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.sel_shift = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/imf_datapath.sv =====
// Datapath of the image median filter: configuration, position counters,
// line store, window sorter and output register. Depends on imf_pkg.
module imf_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [imf_pkg::IDX_BITS-1:0]    cfg_index,
    input  logic [imf_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                            action,
    input  logic [imf_pkg::PIX_BITS-1:0]    pixel,
    input  logic                            out_stall,
    output logic                            out_valid,
    output logic [imf_pkg::PIX_BITS-1:0]    median,
    output logic [imf_pkg::COL_BITS-1:0]    out_col,
    output logic [imf_pkg::ROW_BITS-1:0]    out_row,
    output logic                            frame_last,
    input  imf_pkg::imf_cmd_t               cmd,
    output imf_pkg::imf_status_t            status
);
    import imf_pkg::*;

    logic [WID_BITS-1:0]  width_reg;
    logic [HGT_BITS-1:0]  height_reg;
    logic [RAD_BITS-1:0]  radius_reg;
    logic [WID_BITS-1:0]  eff_w;
    logic [HGT_BITS-1:0]  eff_h;
    logic [POS_BITS-1:0]  total_reg;
    logic [POS_BITS-1:0]  lead_reg;

    logic                 act_reg;
    logic [PIX_BITS-1:0]  pix_reg;

    logic [POS_BITS-1:0]  recv_reg;
    logic [POS_BITS-1:0]  emit_cnt_reg;
    logic [COL_BITS-1:0]  in_col_reg;
    logic [RING_BITS-1:0] in_ring_reg;
    logic [COL_BITS-1:0]  emit_col_reg;
    logic [ROW_BITS-1:0]  emit_row_reg;
    logic [RING_BITS-1:0] emit_ring_reg;

    logic [ROW_BITS-1:0]  wr_row_reg;
    logic [ROW_BITS-1:0]  r1_reg;
    logic [RING_BITS-1:0] wr_ring_reg;
    logic [COL_BITS-1:0]  wc_reg;
    logic [COL_BITS-1:0]  c0_reg;
    logic [COL_BITS-1:0]  c1_reg;

    logic [PIX_BITS-1:0]  mem [MEM_DEPTH];
    logic [PIX_BITS-1:0]  rd_data_reg;
    logic                 rd_valid_reg;

    logic [PIX_BITS-1:0]  vals_reg [WIN_MAX];
    logic [PIX_BITS-1:0]  vals_next [WIN_MAX];
    logic [WIN_MAX-1:0]   gt;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  shift_reg;

    logic                 out_valid_reg;
    logic [PIX_BITS-1:0]  median_reg;
    logic [COL_BITS-1:0]  out_col_reg;
    logic [ROW_BITS-1:0]  out_row_reg;
    logic                 last_reg;

    logic                 do_store;
    logic                 restart;
    logic                 is_last;
    logic [POS_BITS-1:0]  need;
    logic [POS_BITS-1:0]  cap;
    logic [RAD_BITS-1:0]  d_top;
    logic [ROW_BITS-1:0]  r0;
    logic [RING_BITS-1:0] ring0;
    logic [ROW_BITS:0]    row_hi;
    logic [WID_BITS-1:0]  col_hi;

    // Out-of-range register values are clamped to the supported frame.
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WID_BITS'(1);
        else if (width_reg > WID_BITS'(MAX_WIDTH))
            eff_w = WID_BITS'(MAX_WIDTH);
        else
            eff_w = width_reg;
        if (height_reg == '0)
            eff_h = HGT_BITS'(1);
        else if (height_reg > HGT_BITS'(HEIGHT_LIMIT))
            eff_h = HGT_BITS'(HEIGHT_LIMIT);
        else
            eff_h = height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_BITS'(1024);
            height_reg <= HGT_BITS'(1024);
            radius_reg <= RAD_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[WID_BITS-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HGT_BITS-1:0];
                REG_RADIUS: radius_reg <= cfg_data[RAD_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= POS_BITS'(eff_w * eff_h);
        lead_reg  <= POS_BITS'(eff_w * radius_reg) + POS_BITS'(radius_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg <= action;
            pix_reg <= pixel;
        end
    end

    assign do_store = cmd.store && !act_reg && (recv_reg < total_reg);
    assign is_last  = (emit_cnt_reg == total_reg - POS_BITS'(1));
    assign restart  = (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
                      || cfg_index == REG_RADIUS)) || (cmd.emit && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recv_reg      <= '0;
            emit_cnt_reg  <= '0;
            in_col_reg    <= '0;
            in_ring_reg   <= '0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            emit_ring_reg <= '0;
        end
        else if (restart)
        begin
            recv_reg      <= '0;
            emit_cnt_reg  <= '0;
            in_col_reg    <= '0;
            in_ring_reg   <= '0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            emit_ring_reg <= '0;
        end
        else
        begin
            if (do_store)
            begin
                recv_reg <= recv_reg + POS_BITS'(1);
                if (WID_BITS'(in_col_reg) == eff_w - WID_BITS'(1))
                begin
                    in_col_reg  <= '0;
                    in_ring_reg <= (in_ring_reg == RING_BITS'(RING_ROWS - 1)) ? '0
                                   : in_ring_reg + RING_BITS'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + COL_BITS'(1);
                end
            end
            if (cmd.emit)
            begin
                emit_cnt_reg <= emit_cnt_reg + POS_BITS'(1);
                if (WID_BITS'(emit_col_reg) == eff_w - WID_BITS'(1))
                begin
                    emit_col_reg  <= '0;
                    emit_row_reg  <= emit_row_reg + ROW_BITS'(1);
                    emit_ring_reg <= (emit_ring_reg == RING_BITS'(RING_ROWS - 1)) ? '0
                                     : emit_ring_reg + RING_BITS'(1);
                end
                else
                begin
                    emit_col_reg <= emit_col_reg + COL_BITS'(1);
                end
            end
        end
    end

    // An output is due when the input is radius rows plus radius pixels ahead or all in.
    always_comb
    begin
        need = emit_cnt_reg + lead_reg;
        cap  = total_reg - POS_BITS'(1);
        if (need > cap)
            need = cap;
    end

    assign status.emit_ok = (recv_reg > need);

    // Clipped window bounds; the ring row of the top row is found by stepping
    // back from the ring row of the output row.
    always_comb
    begin
        d_top  = (emit_row_reg >= ROW_BITS'(radius_reg)) ? radius_reg
                 : RAD_BITS'(emit_row_reg);
        r0     = emit_row_reg - ROW_BITS'(d_top);
        ring0  = (emit_ring_reg >= RING_BITS'(d_top)) ? emit_ring_reg - RING_BITS'(d_top)
                 : emit_ring_reg + RING_BITS'(RING_ROWS) - RING_BITS'(d_top);
        row_hi = (ROW_BITS+1)'(emit_row_reg) + (ROW_BITS+1)'(radius_reg);
        col_hi = WID_BITS'(emit_col_reg) + WID_BITS'(radius_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_win)
        begin
            wr_row_reg  <= r0;
            wr_ring_reg <= ring0;
            wc_reg      <= (emit_col_reg >= COL_BITS'(radius_reg))
                           ? emit_col_reg - COL_BITS'(radius_reg) : '0;
            c0_reg      <= (emit_col_reg >= COL_BITS'(radius_reg))
                           ? emit_col_reg - COL_BITS'(radius_reg) : '0;
            c1_reg      <= (col_hi < eff_w) ? COL_BITS'(col_hi)
                           : COL_BITS'(eff_w - WID_BITS'(1));
            r1_reg      <= (HGT_BITS'(row_hi) < eff_h) ? ROW_BITS'(row_hi)
                           : ROW_BITS'(eff_h - HGT_BITS'(1));
        end
        else if (cmd.rd_issue)
        begin
            if (wc_reg == c1_reg)
            begin
                wc_reg      <= c0_reg;
                wr_row_reg  <= wr_row_reg + ROW_BITS'(1);
                wr_ring_reg <= (wr_ring_reg == RING_BITS'(RING_ROWS - 1)) ? '0
                               : wr_ring_reg + RING_BITS'(1);
            end
            else
            begin
                wc_reg <= wc_reg + COL_BITS'(1);
            end
        end
    end

    assign status.win_last = (wc_reg == c1_reg) && (wr_row_reg == r1_reg);

    always_ff @(posedge clk)
    begin
        if (do_store)
            mem[{in_ring_reg, in_col_reg}] <= pix_reg;
        if (cmd.rd_issue)
            rd_data_reg <= mem[{wr_ring_reg, wc_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_valid_reg <= 1'b0;
        else
            rd_valid_reg <= cmd.rd_issue;
    end

    // Insertion sort cells: empty cells above the count act as larger than
    // any value, so each cell either keeps, takes its lower neighbor or the
    // new value. Selection then shifts the list down by count/2 places.
    always_comb
    begin
        for (int j = 0; j < WIN_MAX; j++)
            gt[j] = (CNT_BITS'(j) >= cnt_reg) || (vals_reg[j] > rd_data_reg);
        for (int j = 0; j < WIN_MAX; j++)
        begin
            if (cmd.sel_shift)
                vals_next[j] = (j < WIN_MAX - 1) ? vals_reg[(j < WIN_MAX - 1) ? j + 1 : j]
                               : vals_reg[j];
            else if (rd_valid_reg && gt[j])
                vals_next[j] = (j > 0 && gt[(j > 0) ? j - 1 : 0]) ?
                               vals_reg[(j > 0) ? j - 1 : 0] : rd_data_reg;
            else
                vals_next[j] = vals_reg[j];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < WIN_MAX; j++)
            vals_reg[j] <= vals_next[j];
        if (cmd.start_win)
        begin
            cnt_reg   <= '0;
            shift_reg <= '0;
        end
        else
        begin
            if (rd_valid_reg)
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            if (cmd.sel_shift)
                shift_reg <= shift_reg + CNT_BITS'(1);
        end
    end

    assign status.sel_done = (shift_reg == (cnt_reg >> 1));
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            median_reg  <= vals_reg[0];
            out_col_reg <= emit_col_reg;
            out_row_reg <= emit_row_reg;
            last_reg    <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign median     = median_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign frame_last = last_reg;

endmodule

// ===== sv/imf_checker.sv =====
// Port-level checks for the image median filter, bound to the top level.
// Depends on imf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module imf_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [imf_pkg::PIX_BITS-1:0]    median,
    input logic [imf_pkg::COL_BITS-1:0]    out_col,
    input logic [imf_pkg::ROW_BITS-1:0]    out_row,
    input logic                            frame_last
);
    import imf_pkg::*;

    logic [PIX_BITS+COL_BITS+ROW_BITS:0] out_bus;

    assign out_bus = {median, out_col, out_row, frame_last};

    // A result held back by the receiver keeps its values.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bus))

    // One item at a time: after a transfer in, the input is stalled.
    `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

    // A new result only appears while an item is being worked on.
    `ASSERT_SAME(a_out_from_item, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind image_median_filter imf_checker u_imf_checker (.*);
